// ===== sv/wpr_pkg.sv =====
// Shared types and constants for the three-window Williams %R block.
// No dependencies.
package wpr_pkg;
	localparam int NUM_WIN  = 3;
	localparam int PCT_BITS = 14;
	localparam int CFG_BITS = 8;
	localparam int IDX_BITS = 2;
	localparam logic [PCT_BITS-1:0] OUT_FULL = 14'd10000;

	// register indexes
	localparam logic [IDX_BITS-1:0] REG_SHORT = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_MID   = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_LONG  = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic store;      // write the bar into the rings, latch close
		logic scan_init;  // reset the scan offset to the newest bar
		logic scan_rd;    // issue a ring read for the current offset
		logic scan_acc;   // fold read data into extremes
		logic div_start;  // load divider for the window in win_sel
		logic div_step;   // one restoring division step
		logic div_done;   // store the result of window win_sel
		logic out_load;   // move results into the output register
		logic [1:0] win_sel;
	} wpr_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic scan_last;  // current offset is the last one needed
		logic div_last;   // divider on its final step
	} wpr_sts_t;
endpackage

// ===== sv/wpr_datapath.sv =====
// Datapath: price rings, window scan for extremes, shared serial divider.
// Depends on wpr_pkg.
module wpr_datapath #(
	parameter int MAX_WINDOW = 128,
	parameter int PRICE_BITS = 32
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  wpr_pkg::wpr_cmd_t                          cmd,
	output wpr_pkg::wpr_sts_t                          sts,
	input  logic [PRICE_BITS-1:0]                      in_high,
	input  logic [PRICE_BITS-1:0]                      in_low,
	input  logic [PRICE_BITS-1:0]                      in_close,
	input  logic [wpr_pkg::NUM_WIN*wpr_pkg::CFG_BITS-1:0] win_regs,
	output logic [wpr_pkg::PCT_BITS-1:0]               pct_short,
	output logic [wpr_pkg::PCT_BITS-1:0]               pct_mid,
	output logic [wpr_pkg::PCT_BITS-1:0]               pct_long,
	output logic [wpr_pkg::NUM_WIN-1:0]                flat_flags
);
	import wpr_pkg::*;

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int NW = PRICE_BITS + PCT_BITS; // numerator width
	localparam int SW = $clog2(NW + 1);

	// result source for one window
	localparam logic [1:0] MODE_DIV  = 2'd0;
	localparam logic [1:0] MODE_ZERO = 2'd1;
	localparam logic [1:0] MODE_FULL = 2'd2;

	logic [PRICE_BITS-1:0] high_ring [MAX_WINDOW];
	logic [PRICE_BITS-1:0] low_ring  [MAX_WINDOW];
	logic [AW-1:0] slot_q, newest_q, rd_addr_q;
	logic [CW-1:0] seen_q, off_q;
	logic [PRICE_BITS-1:0] close_q, rd_high_q, rd_low_q;
	logic [PRICE_BITS-1:0] hhv_q [NUM_WIN];
	logic [PRICE_BITS-1:0] llv_q [NUM_WIN];
	logic [CW-1:0] n_eff [NUM_WIN];
	logic [NW-1:0] quo_q;
	logic [PRICE_BITS:0] rem_q;
	logic [PRICE_BITS-1:0] den_q;
	logic [SW-1:0] step_q;
	logic [1:0] mode_q;
	logic flat_now_q;
	logic [PCT_BITS-1:0] res_q [NUM_WIN];
	logic [NUM_WIN-1:0] flat_q;
	logic [PRICE_BITS-1:0] sel_h, sel_l;
	logic [CW-1:0] n_max;
	logic [PRICE_BITS:0] rem_sh;
	logic [NW-1:0] num_w;

	// effective window length: clamp to 1..MAX_WINDOW then to bars seen
	always_comb begin
		for (int w = 0; w < NUM_WIN; w++) begin
			logic [CFG_BITS-1:0] r;
			logic [CW+CFG_BITS-1:0] n;
			r = win_regs[w*CFG_BITS +: CFG_BITS];
			n = (CW+CFG_BITS)'(r);
			if (n == '0) n = (CW+CFG_BITS)'(1);
			if (n > (CW+CFG_BITS)'(MAX_WINDOW)) n = (CW+CFG_BITS)'(MAX_WINDOW);
			if (n > (CW+CFG_BITS)'(seen_q)) n = (CW+CFG_BITS)'(seen_q);
			n_eff[w] = CW'(n);
		end
		n_max = n_eff[0];
		if (n_eff[1] > n_max) n_max = n_eff[1];
		if (n_eff[2] > n_max) n_max = n_eff[2];
	end

	assign sts.scan_last = (off_q + CW'(1) >= n_max);
	assign sts.div_last  = (step_q == SW'(1));

	// store bar and advance ring pointers
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			high_ring[slot_q] <= in_high;
			low_ring[slot_q]  <= in_low;
		end
		rd_high_q <= high_ring[rd_addr_q];
		rd_low_q  <= low_ring[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			seen_q <= '0;
		end else if (cmd.store) begin
			slot_q <= (slot_q == AW'(MAX_WINDOW - 1)) ? '0 : slot_q + AW'(1);
			if (seen_q < CW'(MAX_WINDOW)) seen_q <= seen_q + CW'(1);
		end
	end

	// scan: read address walks back from newest; read data comes back registered
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			newest_q <= slot_q;
			close_q  <= in_close;
			rd_addr_q <= slot_q;
		end
		if (cmd.scan_init) begin
			off_q <= '0;
		end
		if (cmd.scan_rd) begin
			off_q <= off_q + CW'(1);
			rd_addr_q <= (rd_addr_q == '0) ? AW'(MAX_WINDOW - 1) : rd_addr_q - AW'(1);
		end
		if (cmd.scan_acc) begin
			for (int w = 0; w < NUM_WIN; w++) begin
				// data now belongs to offset off_q-1
				if (off_q == CW'(1)) begin
					hhv_q[w] <= rd_high_q;
					llv_q[w] <= rd_low_q;
				end else if (off_q <= n_eff[w]) begin
					if (rd_high_q > hhv_q[w]) hhv_q[w] <= rd_high_q;
					if (rd_low_q < llv_q[w])  llv_q[w] <= rd_low_q;
				end
			end
		end
	end

	assign sel_h = hhv_q[cmd.win_sel];
	assign sel_l = llv_q[cmd.win_sel];
	assign num_w = NW'(sel_h - close_q) * NW'(OUT_FULL);
	assign rem_sh = {rem_q[PRICE_BITS-1:0], quo_q[NW-1]};

	// restoring divider, one quotient bit per step
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			flat_now_q <= (sel_h <= sel_l);
			if (sel_h <= sel_l || close_q >= sel_h) mode_q <= MODE_ZERO;
			else if (close_q <= sel_l)              mode_q <= MODE_FULL;
			else                                    mode_q <= MODE_DIV;
			quo_q  <= num_w;
			rem_q  <= '0;
			den_q  <= sel_h - sel_l;
			step_q <= SW'(NW);
		end
		if (cmd.div_step) begin
			step_q <= step_q - SW'(1);
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= rem_sh - {1'b0, den_q};
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
		if (cmd.div_done) begin
			flat_q[cmd.win_sel] <= flat_now_q;
			case (mode_q)
				MODE_ZERO: res_q[cmd.win_sel] <= '0;
				MODE_FULL: res_q[cmd.win_sel] <= OUT_FULL;
				default:   res_q[cmd.win_sel] <= (quo_q > NW'(OUT_FULL)) ? OUT_FULL
					: quo_q[PCT_BITS-1:0];
			endcase
		end
		if (cmd.out_load) begin
			pct_short  <= res_q[0];
			pct_mid    <= res_q[1];
			pct_long   <= res_q[2];
			flat_flags <= flat_q;
		end
	end
endmodule

// ===== sv/wpr_ctrl.sv =====
// Controller: sequences store, scan, three divisions and result handoff.
// Depends on wpr_pkg.
module wpr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output wpr_pkg::wpr_cmd_t cmd,
	input  wpr_pkg::wpr_sts_t sts
);
	import wpr_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_LAST = 3'd2;
	localparam logic [2:0] ST_DST  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0] state_q;
	logic [1:0] win_q;
	logic       outv_q;

	assign out_valid = outv_q;
	// a new request may enter once the previous result left the work area
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.win_sel = win_q;
		cmd.store = in_fire;
		cmd.scan_init = in_fire;
		unique case (state_q)
			ST_IDLE: ;
			ST_SCAN: begin
				cmd.scan_rd  = 1'b1;
				cmd.scan_acc = 1'b1;
			end
			ST_LAST: cmd.scan_acc = 1'b1;
			ST_DST:  cmd.div_start = 1'b1;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_DONE: cmd.div_done = 1'b1;
			ST_OUT:  cmd.out_load = !outv_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			win_q   <= '0;
			outv_q  <= 1'b0;
		end else begin
			// hold the result valid until taken; reload wins over drain
			if (cmd.out_load) outv_q <= 1'b1;
			else if (outv_q && out_ready) outv_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_fire) state_q <= ST_SCAN;
				ST_SCAN: if (sts.scan_last) state_q <= ST_LAST;
				ST_LAST: begin
					win_q   <= REG_SHORT;
					state_q <= ST_DST;
				end
				ST_DST:  state_q <= ST_DIV;
				ST_DIV:  if (sts.div_last) state_q <= ST_DONE;
				ST_DONE: begin
					if (win_q == REG_LONG) state_q <= ST_OUT;
					else begin
						win_q   <= win_q + 2'd1;
						state_q <= ST_DST;
					end
				end
				ST_OUT: if (!outv_q || out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/williams_percent_r_three_window.sv =====
// Three-window Williams %R: one result per price bar.
// A new bar is accepted only in the idle state, after the ring walk and the serial divider
// have finished the previous bar.
// Output register frees the core while a result waits.
// Reset: arst_n clears the write pointer, bar count, registers to 10/20/80; rings undefined.
module williams_percent_r_three_window #(
	parameter int MAX_WINDOW = 128,
	parameter int PRICE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] bar_high,
	input  logic [31:0] bar_low,
	input  logic [31:0] bar_close,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [13:0] pct_short,
	output logic [13:0] pct_mid,
	output logic [13:0] pct_long,
	output logic [2:0]  flat_flags
);
	import wpr_pkg::*;

	logic [NUM_WIN*CFG_BITS-1:0] win_q;
	wpr_cmd_t cmd;
	wpr_sts_t sts;
	logic in_fire;

	assign in_fire = in_valid && in_ready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= {8'd80, 8'd20, 8'd10};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SHORT: win_q[0*CFG_BITS +: CFG_BITS] <= cfg_data;
				REG_MID:   win_q[1*CFG_BITS +: CFG_BITS] <= cfg_data;
				REG_LONG:  win_q[2*CFG_BITS +: CFG_BITS] <= cfg_data;
				default: ;
			endcase
		end
	end

	wpr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
	);

	wpr_datapath #(.MAX_WINDOW(MAX_WINDOW), .PRICE_BITS(PRICE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_high(PRICE_BITS'(bar_high)), .in_low(PRICE_BITS'(bar_low)),
		.in_close(PRICE_BITS'(bar_close)), .win_regs(win_q),
		.pct_short(pct_short), .pct_mid(pct_mid), .pct_long(pct_long),
		.flat_flags(flat_flags)
	);

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.scan_rd, cmd.div_start, cmd.div_step, cmd.div_done, cmd.out_load}) <= 1)
		else $error("controller issued overlapping commands");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !in_ready)
		else $error("input taken during division");
	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && flat_flags[0] |-> pct_short == '0)
		else $error("flat window gave nonzero result");
endmodule

// ===== tb/sv/williams_percent_r_three_window_tb.sv =====
// Testbench for the three-window Williams %R block: random and directed price bars.
// Holds a scoreboard class with its own ring predictor; depends on wpr_pkg and the RTL.
module williams_percent_r_three_window_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wpr_pkg::*;

	localparam int RING = 128;
	localparam longint CYCLE_LIMIT = 5000000;

	typedef struct packed {
		logic [13:0] s;
		logic [13:0] m;
		logic [13:0] l;
		logic [2:0]  f;
	} pct_rec_t;

	class wpr_scoreboard;
		logic [31:0] hi_ring [RING];
		logic [31:0] lo_ring [RING];
		int unsigned slot;
		int unsigned seen;
		logic [7:0] win [NUM_WIN];
		pct_rec_t pending [$];
		int unsigned errors;
		int unsigned checked;

		function new();
			slot = 0;
			seen = 0;
			win[0] = 8'd10;
			win[1] = 8'd20;
			win[2] = 8'd80;
			errors = 0;
			checked = 0;
		endfunction

		function void set_window(int idx, logic [7:0] v);
			win[idx] = v;
		endfunction

		// percent R of one window ending at the newest slot
		function logic [13:0] window_pct(int unsigned n0, int unsigned newest,
				logic [31:0] cl, output logic flat);
			int unsigned n;
			int unsigned idx;
			logic [31:0] hh;
			logic [31:0] ll;
			logic [63:0] q;
			n = (n0 == 0) ? 1 : n0;
			if (n > RING) n = RING;
			if (n > seen) n = seen;
			hh = hi_ring[newest];
			ll = lo_ring[newest];
			for (int k = 1; k < n; k++) begin
				idx = (newest + RING - k) % RING;
				if (hi_ring[idx] > hh) hh = hi_ring[idx];
				if (lo_ring[idx] < ll) ll = lo_ring[idx];
			end
			flat = 1'b0;
			if (hh <= ll) begin
				flat = 1'b1;
				return 14'd0;
			end
			if (cl >= hh) return 14'd0;
			if (cl <= ll) return OUT_FULL;
			q = (64'(hh - cl) * 64'd10000) / 64'(hh - ll);
			if (q > 64'd10000) q = 64'd10000;
			return q[13:0];
		endfunction

		// note an accepted request and queue its expected result
		function void note_bar(logic [31:0] h, logic [31:0] lw, logic [31:0] c);
			pct_rec_t r;
			logic fl;
			int unsigned newest;
			newest = slot;
			hi_ring[newest] = h;
			lo_ring[newest] = lw;
			slot = (slot + 1) % RING;
			if (seen < RING) seen++;
			r.s = window_pct(win[0], newest, c, fl);
			r.f[0] = fl;
			r.m = window_pct(win[1], newest, c, fl);
			r.f[1] = fl;
			r.l = window_pct(win[2], newest, c, fl);
			r.f[2] = fl;
			pending = {pending, r};
		endfunction

		function void check_result(pct_rec_t got);
			pct_rec_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got !== e) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp s=%0d m=%0d l=%0d f=%b got s=%0d m=%0d l=%0d f=%b",
						e.s, e.m, e.l, e.f, got.s, got.m, got.l, got.f);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] bar_high;
	logic [31:0] bar_low;
	logic [31:0] bar_close;
	logic        out_valid;
	logic        out_ready;
	logic [13:0] pct_short;
	logic [13:0] pct_mid;
	logic [13:0] pct_long;
	logic [2:0]  flat_flags;

	wpr_scoreboard sb;
	longint cycles;
	int unsigned bars_sent;
	bit drain_busy;

	williams_percent_r_three_window u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.bar_high(bar_high), .bar_low(bar_low), .bar_close(bar_close),
		.out_valid(out_valid), .out_ready(out_ready), .pct_short(pct_short),
		.pct_mid(pct_mid), .pct_long(pct_long), .flat_flags(flat_flags)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	// check accepted results at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({pct_short, pct_mid, pct_long, flat_flags});
	end

	function automatic int gap_len();
		if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
		return $urandom_range(10, 300);
	endfunction

	// randomly stall the result side at the falling edge
	initial begin
		int g;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (drain_busy) begin
				out_ready = 1'b1;
			end else begin
				g = gap_len();
				if (g > 0) begin
					out_ready = 1'b0;
					repeat (g) @(negedge clk);
				end
				out_ready = 1'b1;
				if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 20)) @(negedge clk);
			end
		end
	end

	task automatic send_bar(logic [31:0] h, logic [31:0] lw, logic [31:0] c, bit idle);
		if (idle) repeat (gap_len()) @(negedge clk);
		in_valid = 1'b1;
		bar_high = h;
		bar_low = lw;
		bar_close = c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_bar(h, lw, c);
		bars_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_idle();
		drain_busy = 1'b1;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
		drain_busy = 1'b0;
	endtask

	task automatic write_window(logic [1:0] idx, logic [7:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		if (idx < 2'd3) sb.set_window(idx, v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// bar around a base price with random spread, sometimes fully random, inverted or flat
	task automatic random_bar(logic [31:0] span);
		logic [31:0] base, a, b, c;
		base = $urandom();
		a = base + $urandom_range(0, span);
		b = base - $urandom_range(0, span);
		c = b + $urandom_range(0, 2 * span + 2) - 1;
		case ($urandom_range(0, 19))
			0: send_bar($urandom(), $urandom(), $urandom(), 1'b1);
			1: send_bar(b, a, c, 1'b1);
			2: send_bar(a, a, a, 1'b1);
			default: send_bar(a, b, c, 1'b1);
		endcase
	endtask

	initial begin
		logic [31:0] drift;
		sb = new();
		cycles = 0;
		bars_sent = 0;
		drain_busy = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SHORT;
		cfg_data = 8'd0;
		in_valid = 1'b0;
		bar_high = 32'd0;
		bar_low = 32'd0;
		bar_close = 32'd0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: warm-up, extremes, flat, inverted, close outside range
		send_bar(32'd100, 32'd50, 32'd75, 1'b0);
		send_bar(32'd100, 32'd100, 32'd100, 1'b0);
		send_bar(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0);
		send_bar(32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0);
		send_bar(32'hFFFF_FFFF, 32'd0, 32'd1, 1'b0);
		send_bar(32'd10, 32'd20, 32'd15, 1'b0);
		send_bar(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5556, 1'b0);
		wait_idle();
		write_window(REG_SHORT, 8'd0);
		write_window(REG_MID, 8'd128);
		write_window(REG_LONG, 8'd255);
		write_window(2'd3, 8'd7);
		for (int i = 0; i < 10; i++)
			send_bar(32'd1000 + i, 32'd900 - i, 32'd950, 1'b0);
		wait_idle();
		write_window(REG_SHORT, 8'd1);
		write_window(REG_MID, 8'd2);
		write_window(REG_LONG, 8'd129);
		send_bar(32'd5, 32'd5, 32'd0, 1'b0);
		send_bar(32'd5, 32'd4, 32'd9, 1'b0);
		wait_idle();

		// random phases with fresh window settings
		for (int ph = 0; ph < 8; ph++) begin
			write_window(REG_SHORT, (ph == 0) ? 8'd1 : 8'($urandom_range(0, 40)));
			write_window(REG_MID, 8'($urandom_range(0, 128)));
			write_window(REG_LONG, (ph == 1) ? 8'd255 : 8'($urandom()));
			drift = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : 32'($urandom_range(0, 5000));
			for (int i = 0; i < 116; i++) random_bar(drift);
			wait_idle();
		end

		$display("covered %0d bars, %0d results checked over several window settings",
			bars_sent, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d failures, %0d results outstanding", sb.errors, sb.pending.size());
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
sv/wpr_pkg.sv
sv/wpr_datapath.sv
sv/wpr_ctrl.sv
sv/williams_percent_r_three_window.sv
tb/sv/williams_percent_r_three_window_tb.sv
